// ----- rtl/core/chit_pkg.sv -----
// Shared widths, operation codes and memory word types of the chained hash index table.
package chit_pkg;

  localparam int OP_W    = 2;
  localparam int KEY_W   = 32;
  localparam int INDEX_W = 10;
  localparam int EPOCH_W = 8;

  localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0] OP_FIRST = 2'd1;
  localparam logic [OP_W-1:0] OP_NEXT  = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

  // Epoch value written by the clearing pass; it never equals the live epoch.
  localparam logic [EPOCH_W-1:0] EPOCH_SWEPT = '0;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = 8'hff;

  typedef struct packed {
    logic [EPOCH_W-1:0] tag;
    logic [INDEX_W-1:0] head;
  } bkt_word_t;

  typedef struct packed {
    logic               valid;
    logic [INDEX_W-1:0] older;
  } link_word_t;

endpackage

// ----- rtl/core/chit_req_if.sv -----
// Request channel of the chained hash index table: operation, key and index.
interface chit_req_if
  import chit_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [KEY_W-1:0]   key;
  logic [INDEX_W-1:0] index;

  modport source (output valid, output op, output key, output index, input ready);
  modport sink   (input valid, input op, input key, input index, output ready);
endinterface

// ----- rtl/core/chit_rsp_if.sv -----
// Response channel of the chained hash index table: found index and its valid flag.
interface chit_rsp_if
  import chit_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] result_index;
  logic               result_valid;

  modport source (output valid, output result_index, output result_valid, input ready);
  modport sink   (input valid, input result_index, input result_valid, output ready);
endinterface

// ----- rtl/core/chained_hash_index_table.sv -----
// Top level of the chained hash index table with bucket and link memories.
//
// Usage: each request transaction on req carries an operation (add, first, next or
// clear), a key whose masked low bits pick a bucket, and an element index. Every
// request yields exactly one response transaction on rsp, in request order. Add and
// clear respond with zero and a clear valid flag; first returns the newest index of
// a bucket; next returns the index added to the same bucket just before a given one.
// A request is registered into the second stage and then into the response register;
// the block takes one request per cycle unless a clearing pass, an epoch wrap or a
// stalled receiver holds req.ready low. A request reads the bucket and link memories
// as it is accepted and completes the read-modify-write in the second stage, with the
// write bypassed into a request that reads the same entry at the edge it lands. Clear
// does not touch the memories: it advances an 8-bit epoch, and a bucket counts as used
// only while its stored epoch matches. When the epoch runs out (every 255th clear) and
// after reset, a clearing pass rewrites every bucket while req.ready is low. If the
// receiver stalls, the response is held in the output register and one further request
// may wait in the second stage; the channel then back-pressures the sender.
module chained_hash_index_table
  import chit_pkg::*;
#(
  parameter int BUCKET_COUNT = 1024,
  parameter int INDEX_DEPTH  = 1024
) (
  input  logic        clk,
  input  logic        rst,
  chit_req_if.sink    req,
  chit_rsp_if.source  rsp
);

  localparam int BKT_AW = $clog2(BUCKET_COUNT);
  localparam int IDX_AW = $clog2(INDEX_DEPTH);
  localparam logic [BKT_AW-1:0] BKT_MASK = BKT_AW'(BUCKET_COUNT - 1);
  localparam logic [BKT_AW-1:0] BKT_LAST = BKT_AW'(BUCKET_COUNT - 1);

  // Memories: the bucket store holds the newest index with its epoch, the link
  // store holds the next older index of each element.
  bkt_word_t  bkt_mem  [BUCKET_COUNT];
  link_word_t link_mem [INDEX_DEPTH];

  // Control state.
  logic               sweeping;
  logic [BKT_AW-1:0]  sweep_addr;
  logic [EPOCH_W-1:0] cur;
  logic               p1_valid;

  // Second-stage payload, captured with the request.
  logic [OP_W-1:0]    p1_op;
  logic [BKT_AW-1:0]  p1_bkt;
  logic [INDEX_W-1:0] p1_index;
  logic               p1_in_range;

  // Registered read data and bypass of the write made in the same cycle as the read.
  bkt_word_t          bkt_rd;
  link_word_t         link_rd;
  logic               fwd_bkt_hit;
  logic               fwd_link_hit;
  bkt_word_t          fwd_bkt;
  link_word_t         fwd_link;

  // Combinational signals.
  logic               req_fire;
  logic               p1_fire;
  logic               epoch_wrap;
  logic [BKT_AW-1:0]  bkt_raddr;
  logic [IDX_AW-1:0]  link_raddr;
  logic               req_in_range;
  bkt_word_t          bkt_word;
  link_word_t         link_word;
  logic               bkt_used;
  logic               bkt_we;
  logic [BKT_AW-1:0]  bkt_waddr;
  bkt_word_t          bkt_wdata;
  logic               link_we;
  logic [IDX_AW-1:0]  link_waddr;
  link_word_t         link_wdata;
  logic [INDEX_W-1:0] res_index;
  logic               res_valid;

  assign bkt_raddr    = req.key[BKT_AW-1:0] & BKT_MASK;
  assign link_raddr   = IDX_AW'(req.index);
  assign req_in_range = 32'(req.index) < 32'(INDEX_DEPTH);

  assign p1_fire    = p1_valid && (!rsp.valid || rsp.ready);
  assign epoch_wrap = p1_valid && (p1_op == OP_CLEAR) && (cur == EPOCH_LAST);

  // A clear that exhausts the epoch holds off new requests, because the clearing
  // pass that follows it owns the bucket memory.
  assign req.ready = !sweeping && !epoch_wrap && (!p1_valid || p1_fire);
  assign req_fire  = req.valid && req.ready;

  assign bkt_word  = fwd_bkt_hit  ? fwd_bkt  : bkt_rd;
  assign link_word = fwd_link_hit ? fwd_link : link_rd;
  assign bkt_used  = bkt_word.tag == cur;

  // Second stage: result and write-back.
  always_comb begin
    res_index  = '0;
    res_valid  = 1'b0;
    link_we    = 1'b0;
    link_waddr = IDX_AW'(p1_index);
    link_wdata = '0;
    bkt_we     = 1'b0;
    bkt_waddr  = p1_bkt;
    bkt_wdata  = '{tag: cur, head: p1_index};
    unique case (p1_op)
      OP_ADD: begin
        if (p1_in_range) begin
          link_we    = p1_fire;
          link_wdata = bkt_used ? link_word_t'{valid: 1'b1, older: bkt_word.head}
                                : link_word_t'('0);
          bkt_we     = p1_fire;
        end
      end
      OP_FIRST: begin
        if (bkt_used) begin
          res_index = bkt_word.head;
          res_valid = 1'b1;
        end
      end
      OP_NEXT: begin
        if (p1_in_range && link_word.valid) begin
          res_index = link_word.older;
          res_valid = 1'b1;
        end
      end
      default: begin
      end
    endcase
    // The clearing pass owns the bucket write port while it runs.
    if (sweeping) begin
      bkt_we    = 1'b1;
      bkt_waddr = sweep_addr;
      bkt_wdata = '{tag: EPOCH_SWEPT, head: '0};
    end
  end

  // Bucket memory: one write and one registered read port.
  always_ff @(posedge clk) begin
    if (bkt_we) begin
      bkt_mem[bkt_waddr] <= bkt_wdata;
    end
    if (req_fire) begin
      bkt_rd <= bkt_mem[bkt_raddr];
    end
  end

  // Link memory: one write and one registered read port.
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (req_fire) begin
      link_rd <= link_mem[link_raddr];
    end
  end

  // First stage capture, including the bypass of a write that lands at the same edge.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_bkt_hit  <= 1'b0;
      fwd_link_hit <= 1'b0;
    end else if (req_fire) begin
      fwd_bkt_hit  <= bkt_we && (bkt_waddr == bkt_raddr);
      fwd_link_hit <= link_we && (link_waddr == link_raddr);
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      p1_op       <= req.op;
      p1_bkt      <= bkt_raddr;
      p1_index    <= req.index;
      p1_in_range <= req_in_range;
      fwd_bkt     <= bkt_wdata;
      fwd_link    <= link_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (req_fire) begin
      p1_valid <= 1'b1;
    end else if (p1_fire) begin
      p1_valid <= 1'b0;
    end
  end

  // Epoch and clearing pass. Reset starts a pass so that no bucket matches the epoch.
  always_ff @(posedge clk) begin
    if (rst) begin
      sweeping   <= 1'b1;
      sweep_addr <= '0;
      cur        <= EPOCH_FIRST;
    end else begin
      if (sweeping) begin
        sweep_addr <= sweep_addr + BKT_AW'(1);
        if (sweep_addr == BKT_LAST) begin
          sweeping <= 1'b0;
        end
      end
      if (p1_fire && (p1_op == OP_CLEAR)) begin
        if (cur == EPOCH_LAST) begin
          cur        <= EPOCH_FIRST;
          sweeping   <= 1'b1;
          sweep_addr <= '0;
        end else begin
          cur <= cur + EPOCH_W'(1);
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (p1_fire) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_fire) begin
      rsp.result_index <= res_index;
      rsp.result_valid <= res_valid;
    end
  end

  // The clearing pass and a request in the second stage never share the write port.
  a_sweep_excl: assert property (@(posedge clk) disable iff (rst)
    !(sweeping && p1_valid))
    else $error("clearing pass overlaps a request in flight");

  // The live epoch never equals the value written by the clearing pass.
  a_epoch_live: assert property (@(posedge clk) disable iff (rst)
    cur != EPOCH_SWEPT)
    else $error("live epoch collides with the swept value");

  // A bucket bypass is only taken when a bucket write happened at the capture edge.
  a_bkt_fwd: assert property (@(posedge clk) disable iff (rst)
    (req_fire && !(bkt_we && (bkt_waddr == bkt_raddr))) |=> !fwd_bkt_hit)
    else $error("bucket bypass without a matching write");

  // A request that enters an empty pipeline completes in the next cycle.
  a_advance: assert property (@(posedge clk) disable iff (rst)
    (req_fire && !p1_valid && !rsp.valid) |=> (p1_valid && p1_fire))
    else $error("request did not advance into the response register");

endmodule

// ----- tb/sv/chit_scoreboard.sv -----
// Scoreboard for the chained hash index table: predicts every response and compares it.
`timescale 1ns / 100ps
module chit_scoreboard
  import chit_pkg::*;
#(
  parameter int BUCKET_COUNT = 1024,
  parameter int INDEX_DEPTH  = 1024
) (
  input  logic       clk,
  input  logic       rst,
  chit_req_if        req,
  chit_rsp_if        rsp,
  output int         mismatches,
  output int         awaited
);

  typedef struct packed {
    logic [INDEX_W-1:0] result_index;
    logic               result_valid;
  } answer_t;

  // Shadow copy of the table: newest index per bucket, bucket occupancy, older-index links.
  logic [INDEX_W-1:0] head_of   [BUCKET_COUNT];
  bit                 head_live [BUCKET_COUNT];
  link_word_t         older_of  [INDEX_DEPTH];

  answer_t awaited_answers [$];
  int      failures = 0;

  function automatic answer_t apply_request(input logic [OP_W-1:0]    op,
                                            input logic [KEY_W-1:0]   key,
                                            input logic [INDEX_W-1:0] index);
    int unsigned bucket;
    answer_t     answer;
    bucket = key & (BUCKET_COUNT - 1);
    answer = '0;
    case (op)
      OP_ADD: begin
        if (index < INDEX_DEPTH) begin
          if (head_live[bucket]) begin
            older_of[index] = '{valid: 1'b1, older: head_of[bucket]};
          end else begin
            older_of[index] = '0;
          end
          head_of[bucket]   = index;
          head_live[bucket] = 1'b1;
        end
      end
      OP_FIRST: begin
        if (head_live[bucket]) answer = '{result_index: head_of[bucket], result_valid: 1'b1};
      end
      OP_NEXT: begin
        if (index < INDEX_DEPTH && older_of[index].valid) begin
          answer = '{result_index: older_of[index].older, result_valid: 1'b1};
        end
      end
      OP_CLEAR: begin
        foreach (head_live[b]) head_live[b] = 1'b0;
      end
      default: ;
    endcase
    return answer;
  endfunction

  task automatic flag(input string what, input answer_t want, input answer_t got);
    failures++;
    if (failures <= 10) begin
      $display("%t: %s: expected index %0d valid %0b, got index %0d valid %0b", $time, what,
               want.result_index, want.result_valid, got.result_index, got.result_valid);
    end
  endtask

  always @(posedge clk) begin
    answer_t want;
    answer_t got;
    if (rst) begin
      foreach (head_live[b]) head_live[b] = 1'b0;
      awaited_answers.delete();
    end else begin
      // The response side is handled first: a response never belongs to a request
      // accepted at the same edge.
      if (rsp.valid && rsp.ready) begin
        got = '{result_index: rsp.result_index, result_valid: rsp.result_valid};
        if (awaited_answers.size() == 0) begin
          flag("response with no request outstanding", '0, got);
        end else begin
          want = awaited_answers.pop_front();
          if (got.result_index !== want.result_index || got.result_valid !== want.result_valid)
            flag("response mismatch", want, got);
        end
      end
      if (req.valid && req.ready) begin
        awaited_answers.push_back(apply_request(req.op, req.key, req.index));
      end
    end
    mismatches <= failures;
    awaited    <= awaited_answers.size();
  end

endmodule

// ----- tb/sv/chained_hash_index_table_tb.sv -----
// Testbench top for the chained hash index table: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module chained_hash_index_table_tb;
  import chit_pkg::*;

  localparam int BUCKET_COUNT = 1024;
  localparam int INDEX_DEPTH  = 1024;

  logic clk = 1'b0;
  logic rst = 1'b1;

  chit_req_if req ();
  chit_rsp_if rsp ();

  int mismatches;
  int awaited;

  // Bookkeeping for the stimulus only: how many request transactions have been
  // offered and accepted, how many responses have been taken, and which element
  // indices have ever been added (a next on any other index is never issued).
  int          items_sent = 0;
  int          delivered  = 0;
  bit          was_added [INDEX_DEPTH];
  int unsigned added_pool [$];
  logic        calm;

  chained_hash_index_table #(
    .BUCKET_COUNT (BUCKET_COUNT),
    .INDEX_DEPTH  (INDEX_DEPTH)
  ) u_top (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  chit_scoreboard #(
    .BUCKET_COUNT (BUCKET_COUNT),
    .INDEX_DEPTH  (INDEX_DEPTH)
  ) u_scoreboard (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rsp        (rsp),
    .mismatches (mismatches),
    .awaited    (awaited)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // A stretch of the run in which neither side idles, so that the block is driven
  // at its full rate of one transaction per cycle.
  assign calm = (items_sent >= 520) && (items_sent < 680);

  always @(posedge clk) begin
    if (rsp.valid && rsp.ready) delivered <= delivered + 1;
  end

  // Keys: most of them fall into a handful of buckets so that chains grow long,
  // while the rest are fully random so that every key bit is exercised.
  function automatic logic [KEY_W-1:0] pick_key();
    logic [KEY_W-1:0] key;
    key = $urandom();
    if ($urandom_range(0, 99) < 60) key[INDEX_W-1:0] = INDEX_W'($urandom_range(0, 7));
    return key;
  endfunction

  // Offers one request transaction and returns at the rising edge that accepts it.
  // Inputs only ever change at the falling edge.
  task automatic offer(input logic [OP_W-1:0]    op,
                       input logic [KEY_W-1:0]   key,
                       input logic [INDEX_W-1:0] index);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 33) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid <= 1'b1;
    req.op    <= op;
    req.key   <= key;
    req.index <= index;
    if (op == OP_ADD && !was_added[index]) begin
      was_added[index] = 1'b1;
      added_pool.push_back(32'(index));
    end
    items_sent++;
    do @(posedge clk); while (!req.ready);
  endtask

  // Receiver: takes responses at random, with one long hold-off once a few hundred
  // responses have come, so that the output register and the second stage fill up
  // and the block back-pressures the sender.
  initial begin
    bit held;
    held      = 1'b0;
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && delivered >= 250) begin
        held = 1'b1;
        rsp.ready <= 1'b0;
        repeat (150) @(negedge clk);
      end
      rsp.ready <= calm || ($urandom_range(0, 99) >= 33);
    end
  end

  initial begin
    int unsigned      pick;
    int               item;
    bit               storm;
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
    logic [INDEX_W-1:0] index;

    req.valid = 1'b0;
    req.op    = OP_ADD;
    req.key   = '0;
    req.index = '0;

    repeat (6) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed opening. The block first runs its clearing pass, during which it
    // holds ready low; the first transaction simply waits for it.
    offer(OP_FIRST, 32'h0000_0000, 10'd0);     // empty bucket straight after reset
    offer(OP_CLEAR, 32'h0000_0000, 10'd0);     // clear of an already empty table
    offer(OP_ADD,   32'hFFFF_FFFF, 10'd1023);  // all-ones key and the top index
    offer(OP_FIRST, 32'h0000_03FF, 10'd0);     // same bucket reached with high bits clear
    offer(OP_ADD,   32'hABCD_E3FF, 10'd0);     // push index zero in front of 1023
    offer(OP_FIRST, 32'h5555_57FF, 10'd0);
    offer(OP_NEXT,  32'h0000_0000, 10'd0);     // link from zero back to 1023
    offer(OP_NEXT,  32'hFFFF_FFFF, 10'd1023);  // end of the chain
    offer(OP_ADD,   32'h0000_0000, 10'd5);
    offer(OP_ADD,   32'h8000_0000, 10'd6);     // bucket zero again via the top key bit
    offer(OP_NEXT,  32'h0000_0000, 10'd6);
    offer(OP_FIRST, 32'h8000_0400, 10'd0);
    offer(OP_CLEAR, 32'hFFFF_FFFF, 10'd1023);
    offer(OP_FIRST, 32'h0000_03FF, 10'd0);     // buckets are empty after a clear
    offer(OP_NEXT,  32'h0000_0000, 10'd0);     // but the old links survive it
    offer(OP_NEXT,  32'h0000_0000, 10'd6);
    offer(OP_ADD,   32'h0000_03FF, 10'd7);     // a fresh chain in a cleared bucket
    offer(OP_NEXT,  32'h0000_0000, 10'd7);
    offer(OP_ADD,   32'h0000_0000, 10'd5);     // re-adding an index relinks it
    offer(OP_NEXT,  32'h0000_0000, 10'd5);
    offer(OP_ADD,   32'h0000_0000, 10'd6);     // add to one bucket, then read it back with first and next
    offer(OP_FIRST, 32'h0000_0000, 10'd0);
    offer(OP_NEXT,  32'h0000_0000, 10'd6);

    // Random part. Between items 100 and 400 clears dominate, which can push the epoch
    // past its last value and force a second clearing pass; elsewhere clears are
    // rare so that long chains build up between them.
    for (item = 0; item < 1030; item++) begin
      if (item == 700) begin
        // Let the pipeline drain completely before carrying on.
        @(negedge clk) req.valid <= 1'b0;
        wait (awaited == 0);
      end
      storm = (item >= 100) && (item < 400);
      key   = pick_key();
      index = INDEX_W'($urandom_range(0, INDEX_DEPTH - 1));
      if ($urandom_range(0, 99) < (storm ? 85 : 3)) begin
        op = OP_CLEAR;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          op = OP_ADD;
          // Now and then an index that is already in use is added again.
          if (added_pool.size() != 0 && $urandom_range(0, 99) < 20)
            index = INDEX_W'(added_pool[$urandom_range(0, added_pool.size() - 1)]);
        end else if (pick < 70 || added_pool.size() == 0) begin
          op = OP_FIRST;
        end else begin
          op    = OP_NEXT;
          index = INDEX_W'(added_pool[$urandom_range(0, added_pool.size() - 1)]);
        end
      end
      offer(op, key, index);
    end
    @(negedge clk) req.valid <= 1'b0;

    wait (awaited == 0);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, including both clearing passes.
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/chit_pkg.sv
rtl/core/chit_req_if.sv
rtl/core/chit_rsp_if.sv
rtl/core/chained_hash_index_table.sv
tb/sv/chit_scoreboard.sv
tb/sv/chained_hash_index_table_tb.sv
